// ===== rtl/etnf_pkg.sv =====
package etnf_pkg;

    // Field widths
    localparam int IDX_W      = 13;
    localparam int OCT_W      = 5;
    localparam int NPO_W      = 8;
    localparam int REF_W      = 32;
    localparam int FREQ_W     = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Defaults for top-level parameters
    localparam int STEPS_DEFAULT       = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_FIRST        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_LAST         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTES_PER_OCTAVE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_FREQUENCY = 2'd3;

    // Register reset values
    localparam logic signed [OCT_W-1:0] OCTAVE_FIRST_RST = 5'sd0;
    localparam logic signed [OCT_W-1:0] OCTAVE_LAST_RST  = 5'sd8;
    localparam logic [NPO_W-1:0]        NPO_RST          = 8'd12;
    localparam logic [REF_W-1:0]        REF_RST          = 32'd28835840;

    // Datapath widths (sized for the largest steps-per-octave value)
    localparam int SPAN_W    = 6;   // octave count, 1..32
    localparam int LEN_W     = 14;  // table length, up to 32*255
    localparam int POS_W     = 15;  // idx + (first+bias)*n
    localparam int P_W       = 23;  // biased exponent numerator
    localparam int D_W       = 16;  // steps * notes
    localparam int INT_BITS  = 7;   // integer part of the biased exponent
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = INT_BITS + FRAC_BITS;
    localparam int MAN_W     = 32;  // Q30 mantissa
    localparam int V_W       = 64;  // reference * mantissa, Q46
    localparam int SH_W      = 7;
    localparam int RES_W     = 49;  // after a right shift of at least 15

    // Exponent offsets: numerator is biased by OCT_BIAS octaves to stay positive
    localparam int OCT_BIAS   = 73;
    localparam int TUNE_OFS   = 57;
    localparam int SHIFT_BASE = 30 + OCT_BIAS;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    typedef struct packed {
        logic signed [OCT_W-1:0] octave_first;
        logic signed [OCT_W-1:0] octave_last;
        logic [NPO_W-1:0]        notes_per_octave;
        logic [REF_W-1:0]        reference_frequency;
    } cfg_t;

    typedef struct packed {
        logic             oor;
        logic [POS_W-1:0] pos;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Root-of-two factor t_k in Q30: repeated integer square roots of 2.0
    function automatic logic [MAN_W-1:0] etnf_factor(input int k);
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        int          j;
        int          i;
        t = 64'd1 << 31;
        for (j = 1; j <= 16; j++)
        begin
            if (j <= k)
            begin
                x   = t << 30;
                res = '0;
                b   = 64'd1 << 62;
                for (i = 0; i < 32; i++)
                begin
                    if (b != 0)
                    begin
                        if (x >= res + b)
                        begin
                            x   = x - (res + b);
                            res = (res >> 1) + b;
                        end
                        else
                        begin
                            res = res >> 1;
                        end
                        b = b >> 2;
                    end
                end
                t = res;
            end
        end
        return t[MAN_W-1:0];
    endfunction

endpackage

// ===== rtl/etnf_if.sv =====
interface etnf_in_if import etnf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] table_index;

    modport source (output valid, output table_index, input ready);
    modport sink (input valid, input table_index, output ready);
endinterface

interface etnf_out_if import etnf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] note_frequency;
    logic              index_out_of_range;
    logic              saturated;

    modport source (output valid, output note_frequency, output index_out_of_range,
                    output saturated, input ready);
    modport sink (input valid, input note_frequency, input index_out_of_range,
                  input saturated, output ready);
endinterface

interface etnf_cfg_if import etnf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/etnf_front.sv =====
module etnf_front import etnf_pkg::*;
(
    input  cfg_t       cfg,
    etnf_in_if.sink    item,
    input  logic       qfull,
    output logic       push,
    output qent_t      entry
);

    logic signed [OCT_W-1:0] lo;
    logic signed [OCT_W-1:0] hi;
    logic [SPAN_W-1:0]       span;
    logic [LEN_W-1:0]        len;
    logic [6:0]              oct_biased;
    logic [POS_W-1:0]        base;

    // Order the octave span
    always_comb
    begin
        if (cfg.octave_last < cfg.octave_first)
        begin
            lo = cfg.octave_last;
            hi = cfg.octave_first;
        end
        else
        begin
            lo = cfg.octave_first;
            hi = cfg.octave_last;
        end
    end

    // Table length and range check
    assign span = SPAN_W'(signed'({hi[OCT_W-1], hi}) - signed'({lo[OCT_W-1], lo})) + SPAN_W'(1);
    assign len  = LEN_W'(span) * LEN_W'(cfg.notes_per_octave);

    // Biased linear note position: idx + (first + bias) * n
    assign oct_biased = 7'(signed'({{2{lo[OCT_W-1]}}, lo}) + 7'(OCT_BIAS));
    assign base       = POS_W'(oct_biased) * POS_W'(cfg.notes_per_octave);

    assign entry.oor = (cfg.notes_per_octave == '0) || (LEN_W'(item.table_index) >= len);
    assign entry.pos = base + POS_W'(item.table_index);

    assign item.ready = !qfull;
    assign push       = item.valid && !qfull;

endmodule

// ===== rtl/etnf_queue.sv =====
module etnf_queue import etnf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qent_t  din,
    input  logic   pop,
    output qent_t  dout,
    output qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qent_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== rtl/etnf_back.sv =====
module etnf_back import etnf_pkg::*;
#(
    parameter int STEPS = STEPS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       qempty,
    input  qent_t      head,
    output logic       pop,
    etnf_out_if.source result
);

    typedef struct packed {
        logic           valid;
        logic           oor;
        logic [P_W-1:0] r;
        logic [Q_W-1:0] q;
    } div_t;

    typedef struct packed {
        logic                 valid;
        logic                 oor;
        logic [INT_BITS-1:0]  qint;
        logic [FRAC_BITS-1:0] f;
        logic [MAN_W-1:0]     m;
    } man_t;

    typedef struct packed {
        logic                valid;
        logic                oor;
        logic [INT_BITS-1:0] qint;
        logic [V_W-1:0]      v;
    } prod_t;

    typedef struct packed {
        logic             valid;
        logic             oor;
        logic [RES_W-1:0] res;
    } rnd_t;

    logic              en;
    logic [D_W-1:0]    d;
    logic [P_W-1:0]    p_next;
    div_t              div_reg [0:Q_W];
    man_t              man_s0;
    man_t              man_reg [1:FRAC_BITS];
    prod_t             prod_reg;
    rnd_t              rnd_reg;
    logic [SH_W-1:0]   sh;
    logic [V_W-1:0]    rnd_sum;
    logic [V_W-1:0]    rnd_shift;
    logic [RES_W-1:0]  res_next;
    logic              sat_next;
    logic              out_valid_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic              oor_reg;
    logic              sat_reg;

    // Whole pipeline advances unless the output transaction stalls
    assign en  = !out_valid_reg || result.ready;
    assign pop = en && !qempty;

    // Divisor and biased numerator S*pos - 57*n
    assign d      = D_W'(cfg.notes_per_octave) * D_W'(STEPS);
    assign p_next = P_W'(head.pos) * P_W'(STEPS)
                    - P_W'(cfg.notes_per_octave) * P_W'(TUNE_OFS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg[0].valid <= 1'b0;
        end
        else if (en)
        begin
            div_reg[0].valid <= pop;
            div_reg[0].oor   <= head.oor;
            div_reg[0].r     <= head.oor ? '0 : p_next;
            div_reg[0].q     <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage: integer bits, then fraction
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        logic [P_W-1:0] r_in;
        logic [P_W-1:0] trial;
        logic [P_W-1:0] r_next;
        logic           take;

        if (j < INT_BITS)
        begin : g_int
            assign r_in  = div_reg[j].r;
            assign trial = P_W'(d) << (INT_BITS - 1 - j);
        end
        else
        begin : g_frac
            assign r_in  = div_reg[j].r << 1;
            assign trial = P_W'(d);
        end

        assign take   = (r_in >= trial);
        assign r_next = take ? (r_in - trial) : r_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[j+1].valid <= 1'b0;
            end
            else if (en)
            begin
                div_reg[j+1].valid <= div_reg[j].valid;
                div_reg[j+1].oor   <= div_reg[j].oor;
                div_reg[j+1].r     <= r_next;
                div_reg[j+1].q     <= div_reg[j].q | (Q_W'(take) << (Q_W - 1 - j));
            end
        end
    end

    // Split exponent into integer part and fraction, mantissa starts at 1.0
    assign man_s0.valid = div_reg[Q_W].valid;
    assign man_s0.oor   = div_reg[Q_W].oor;
    assign man_s0.qint  = div_reg[Q_W].q[Q_W-1:FRAC_BITS];
    assign man_s0.f     = div_reg[Q_W].q[FRAC_BITS-1:0];
    assign man_s0.m     = MAN_W'(64'd1 << 30);

    // One root-of-two multiply per fraction bit, most significant first
    for (genvar j = 0; j < FRAC_BITS; j++)
    begin : g_man
        localparam logic [MAN_W-1:0] T = etnf_factor(j + 1);
        man_t           src;
        logic [V_W-1:0] prod;

        if (j == 0)
        begin : g_first
            assign src = man_s0;
        end
        else
        begin : g_rest
            assign src = man_reg[j];
        end

        assign prod = V_W'(src.m) * V_W'(T) + (V_W'(1) << 29);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                man_reg[j+1].valid <= 1'b0;
            end
            else if (en)
            begin
                man_reg[j+1].valid <= src.valid;
                man_reg[j+1].oor   <= src.oor;
                man_reg[j+1].qint  <= src.qint;
                man_reg[j+1].f     <= src.f;
                man_reg[j+1].m     <= src.f[FRAC_BITS-1-j] ? prod[61:30] : src.m;
            end
        end
    end

    // Scale by reference frequency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            prod_reg.valid <= man_reg[FRAC_BITS].valid;
            prod_reg.oor   <= man_reg[FRAC_BITS].oor;
            prod_reg.qint  <= man_reg[FRAC_BITS].qint;
            prod_reg.v     <= V_W'(cfg.reference_frequency) * V_W'(man_reg[FRAC_BITS].m);
        end
    end

    // Round-half-up right shift down to Q16; the shift is always to the right
    assign sh        = SH_W'(SHIFT_BASE) - prod_reg.qint;
    assign rnd_sum   = prod_reg.v + (V_W'(1) << (sh - SH_W'(1)));
    assign rnd_shift = rnd_sum >> sh;
    assign res_next  = (sh >= SH_W'(64)) ? '0 : rnd_shift[RES_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            rnd_reg.valid <= prod_reg.valid;
            rnd_reg.oor   <= prod_reg.oor;
            rnd_reg.res   <= res_next;
        end
    end

    // Clip and output register
    assign sat_next = !rnd_reg.oor && (rnd_reg.res > RES_W'(FREQ_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rnd_reg.valid;
            oor_reg       <= rnd_reg.oor;
            sat_reg       <= sat_next;
            if (rnd_reg.oor)
            begin
                freq_reg <= '0;
            end
            else if (sat_next)
            begin
                freq_reg <= FREQ_MAX;
            end
            else
            begin
                freq_reg <= rnd_reg.res[FREQ_W-1:0];
            end
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.note_frequency     = freq_reg;
    assign result.index_out_of_range = oor_reg;
    assign result.saturated          = sat_reg;

endmodule

// ===== rtl/equal_tempered_note_frequency_core.sv =====
// Pipeline: the queue head is taken into the input register, then the 23-stage
// restoring divider, 16 root-of-two multiply stages and 3 output stages.
// Throughput: one item per cycle; the pipeline halts as a whole while a result stalls,
// and a QUEUE_DEPTH-entry queue (default 2) between classifier and datapath keeps the
// input side taking items until it fills.
// Reset (rst_n, asynchronous, active low) clears valid bits, queue pointers and
// loads the register defaults; no clearing pass.
module equal_tempered_note_frequency_core import etnf_pkg::*;
#(
    parameter int STEPS_IN_OCTAVE = STEPS_DEFAULT,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    etnf_cfg_if.sink   cfg,
    etnf_in_if.sink    item,
    etnf_out_if.source result
);

    cfg_t   cfg_reg;
    qent_t  entry;
    qent_t  head;
    qstat_t qstat;
    logic   push;
    logic   pop;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.octave_first        <= OCTAVE_FIRST_RST;
            cfg_reg.octave_last         <= OCTAVE_LAST_RST;
            cfg_reg.notes_per_octave    <= NPO_RST;
            cfg_reg.reference_frequency <= REF_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_OCTAVE_FIRST:        cfg_reg.octave_first        <= cfg.data[OCT_W-1:0];
                REG_OCTAVE_LAST:         cfg_reg.octave_last         <= cfg.data[OCT_W-1:0];
                REG_NOTES_PER_OCTAVE:    cfg_reg.notes_per_octave    <= cfg.data[NPO_W-1:0];
                REG_REFERENCE_FREQUENCY: cfg_reg.reference_frequency <= cfg.data[REF_W-1:0];
            endcase
        end
    end

    etnf_front u_front
    (
        .cfg   (cfg_reg),
        .item  (item),
        .qfull (qstat.full),
        .push  (push),
        .entry (entry)
    );

    etnf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (entry),
        .pop   (pop),
        .dout  (head),
        .stat  (qstat)
    );

    etnf_back #(.STEPS(STEPS_IN_OCTAVE)) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .qempty (qstat.empty),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

`ifndef SYNTHESIS
    // Out-of-range results carry zero and no clip flag
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.index_out_of_range
        |-> result.note_frequency == '0 && !result.saturated)
        else $error("out-of-range result not zero");

    // Clipped results sit at full scale
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |-> result.note_frequency == FREQ_MAX)
        else $error("saturated result not at maximum");

    // An accepted item is held in the queue in the next cycle
    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !qstat.empty)
        else $error("queue empty after input transaction");
`endif

endmodule
